>>> hdl/sprt_pkg.sv
`timescale 1ns / 1ps
package sprt_pkg;

  localparam int unsigned ADDR_W = 48;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned CFG_W  = 20;
  localparam int unsigned STAT_W = 8;
  localparam int unsigned BTN_W  = 2;

  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;

  // config register indexes (paddr[2])
  localparam logic REG_REPEAT_WAIT  = 1'b0;
  localparam logic REG_CANCEL_AFTER = 1'b1;

  localparam logic [CFG_W-1:0] REPEAT_WAIT_RST  = CFG_W'(500);
  localparam logic [CFG_W-1:0] CANCEL_AFTER_RST = CFG_W'(3000);

  // status byte bits
  localparam int unsigned BIT_PRESSED = 0;
  localparam int unsigned BIT_A1      = 2;
  localparam int unsigned BIT_B0      = 3;
  localparam int unsigned BIT_B1      = 4;

  localparam int unsigned RES_CNT_W = 4;
  localparam logic [RES_CNT_W-1:0] MAX_RESULTS = RES_CNT_W'(8);

  localparam int unsigned CMD_DEPTH = 2;
  localparam int unsigned RES_DEPTH = 4;

  typedef enum logic [1:0] {
    BTN_A0 = 2'd0,
    BTN_A1 = 2'd1,
    BTN_B0 = 2'd2,
    BTN_B1 = 2'd3
  } button_e;

  typedef enum logic [1:0] {
    EV_PUSHED = 2'd0,
    EV_SHORT  = 2'd1,
    EV_LONG   = 2'd2,
    EV_REPEAT = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    OP_PUSH    = 2'd0,
    OP_RELEASE = 2'd1,
    OP_TICK    = 2'd2
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [BTN_W-1:0]  button;
    logic [ADDR_W-1:0] address;
    logic [TIME_W-1:0] now;
  } cmd_t;

  typedef struct packed {
    kind_e             kind;
    logic [BTN_W-1:0]  button;
    logic [ADDR_W-1:0] address;
    logic              full;
    logic              last;
  } res_t;

  typedef struct packed {
    logic [ADDR_W-1:0] address;
    logic [BTN_W-1:0]  button;
    logic [TIME_W-1:0] push_time;
  } entry_t;

endpackage

>>> hdl/switch_press_repeat_tracker.sv
`timescale 1ns / 1ps
// Push-button switch tracker. Switch reports and repeat ticks enter through a
// two-deep command queue; a back end then walks the press table (a RAM of
// TABLE_ENTRIES rows with flip-flop valid bits, all cleared by reset) one row
// per cycle, unless a full result queue stalls it, through the RAM's single
// read port. A report gives one result, a tick up to eight Repeat results;
// last_of_run marks the final result of an input. Results wait in a
// four-deep queue. repeat_wait_ms (address 0) and cancel_after_ms (address 4)
// are written over the APB port; the user must write them only while the
// block is idle, as the block itself does not enforce it.
module switch_press_repeat_tracker
  import sprt_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,

  input  logic              push,
  output logic              full,
  input  logic              command_i,
  input  logic [ADDR_W-1:0] device_address_i,
  input  logic [STAT_W-1:0] switch_status_i,
  input  logic [TIME_W-1:0] now_ms_i,

  output logic              empty,
  input  logic              pop,
  output logic [1:0]        event_kind_o,
  output logic [BTN_W-1:0]  button_id_o,
  output logic [ADDR_W-1:0] event_address_o,
  output logic              table_full_o,
  output logic              last_of_run_o,

  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  logic [CFG_W-1:0] repeat_wait_q, cancel_after_q;
  logic             cfg_we, reg_sel;

  cmd_t cmd;
  logic cmd_empty, cmd_pop;
  res_t res_in, res_out;
  logic res_push, res_full;
  logic [$bits(res_t)-1:0] res_vec;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      repeat_wait_q  <= REPEAT_WAIT_RST;
      cancel_after_q <= CANCEL_AFTER_RST;
    end else if (cfg_we) begin
      unique case (reg_sel)
        REG_REPEAT_WAIT:  repeat_wait_q  <= pwdata[CFG_W-1:0];
        REG_CANCEL_AFTER: cancel_after_q <= pwdata[CFG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_REPEAT_WAIT:  prdata = APB_DW'(repeat_wait_q);
      REG_CANCEL_AFTER: prdata = APB_DW'(cancel_after_q);
      default:          prdata = '0;
    endcase
  end

  sprt_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push_i           (push),
    .command_i        (command_i),
    .device_address_i (device_address_i),
    .switch_status_i  (switch_status_i),
    .now_ms_i         (now_ms_i),
    .full_o           (full),
    .pop_i            (cmd_pop),
    .cmd_o            (cmd),
    .empty_o          (cmd_empty)
  );

  sprt_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_empty_i    (cmd_empty),
    .cmd_i          (cmd),
    .cmd_pop_o      (cmd_pop),
    .repeat_wait_i  (repeat_wait_q),
    .cancel_after_i (cancel_after_q),
    .res_full_i     (res_full),
    .res_push_o     (res_push),
    .res_o          (res_in)
  );

  sprt_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_vec),
    .empty_o (empty)
  );

  assign res_out         = res_t'(res_vec);
  assign event_kind_o    = res_out.kind;
  assign button_id_o     = res_out.button;
  assign event_address_o = res_out.address;
  assign table_full_o    = res_out.full;
  assign last_of_run_o   = res_out.last;

`ifndef SYNTH
  // back end never offers a beat the result queue cannot take
  a_res_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> !res_full)
    else $error("result beat pushed into full queue");

  a_full_only_pushed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && table_full_o) |-> (event_kind_o == EV_PUSHED))
    else $error("table_full on a non-Pushed result");

  // reports give exactly one result, so it is always the last of its run
  a_report_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (event_kind_o != EV_REPEAT)) |-> last_of_run_o)
    else $error("report result without last_of_run");
`endif

endmodule

>>> hdl/sprt_ram.sv
`timescale 1ns / 1ps
module sprt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/sprt_fifo.sv
`timescale 1ns / 1ps
module sprt_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

>>> hdl/sprt_front.sv
`timescale 1ns / 1ps
module sprt_front
  import sprt_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic              command_i,
  input  logic [ADDR_W-1:0] device_address_i,
  input  logic [STAT_W-1:0] switch_status_i,
  input  logic [TIME_W-1:0] now_ms_i,
  output logic              full_o,
  input  logic              pop_i,
  output cmd_t              cmd_o,
  output logic              empty_o
);

  cmd_t                     cmd_in;
  button_e                  button;
  logic [$bits(cmd_t)-1:0]  cmd_vec;

  // button select by priority, highest bit wins
  always_comb begin
    if (switch_status_i[BIT_B1]) begin
      button = BTN_B1;
    end else if (switch_status_i[BIT_B0]) begin
      button = BTN_B0;
    end else if (switch_status_i[BIT_A1]) begin
      button = BTN_A1;
    end else begin
      button = BTN_A0;
    end
  end

  always_comb begin
    cmd_in.button  = button;
    cmd_in.address = device_address_i;
    cmd_in.now     = now_ms_i;
    if (command_i) begin
      cmd_in.op = OP_TICK;
    end else if (switch_status_i[BIT_PRESSED]) begin
      cmd_in.op = OP_PUSH;
    end else begin
      cmd_in.op = OP_RELEASE;
    end
  end

  sprt_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .data_i  (cmd_in),
    .full_o  (full_o),
    .pop_i   (pop_i),
    .data_o  (cmd_vec),
    .empty_o (empty_o)
  );

  assign cmd_o = cmd_t'(cmd_vec);

endmodule

>>> hdl/sprt_back.sv
`timescale 1ns / 1ps
module sprt_back
  import sprt_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cmd_empty_i,
  input  cmd_t             cmd_i,
  output logic             cmd_pop_o,
  input  logic [CFG_W-1:0] repeat_wait_i,
  input  logic [CFG_W-1:0] cancel_after_i,
  input  logic             res_full_i,
  output logic             res_push_o,
  output res_t             res_o
);

  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  state_e                   state_q;
  cmd_t                     cmd_q;
  logic [IDX_W-1:0]         idx_q;
  logic [TABLE_ENTRIES-1:0] valid_q;
  logic                     found_q, long_q, free_v_q, any_q, pend_v_q;
  logic [IDX_W-1:0]         slot_q, free_q;
  logic [TIME_W-1:0]        min_age_q;
  res_t                     pend_q;
  logic [RES_CNT_W-1:0]     cnt_q;

  logic [$bits(entry_t)-1:0] rd_vec;
  entry_t                   rd_entry, wr_entry;
  logic [IDX_W-1:0]         raddr, wslot;
  logic [TIME_W-1:0]        age, wait_ext, cancel_ext;
  logic                     entry_v, match, hit, last_entry;
  logic                     scan_stall, scan_adv, tbl_full, done_need, done_go, ram_we;
  res_t                     done_res;

  assign rd_entry   = entry_t'(rd_vec);
  assign entry_v    = valid_q[idx_q];
  assign age        = cmd_q.now - rd_entry.push_time;
  assign wait_ext   = TIME_W'(repeat_wait_i);
  assign cancel_ext = TIME_W'(cancel_after_i);
  assign match      = entry_v && (rd_entry.address == cmd_q.address);
  assign hit        = (cmd_q.op == OP_TICK) && entry_v && (age > wait_ext)
                      && (cnt_q < MAX_RESULTS);
  assign last_entry = (idx_q == LAST_IDX);

  // a new repeat hit forces out the held one; wait if the result queue is full
  assign scan_stall = hit && pend_v_q && res_full_i;
  assign scan_adv   = (state_q == ST_SCAN) && !scan_stall;

  assign tbl_full  = !found_q && !free_v_q;
  assign wslot     = found_q ? slot_q : free_q;
  assign done_need = (cmd_q.op != OP_TICK) || pend_v_q;
  assign done_go   = (state_q == ST_DONE) && !(done_need && res_full_i);

  always_comb begin
    done_res         = pend_q;
    done_res.last    = 1'b1;
    case (cmd_q.op)
      OP_PUSH: begin
        done_res.kind    = EV_PUSHED;
        done_res.button  = cmd_q.button;
        done_res.address = cmd_q.address;
        done_res.full    = tbl_full;
      end
      OP_RELEASE: begin
        done_res.kind    = (found_q && long_q) ? EV_LONG : EV_SHORT;
        done_res.button  = cmd_q.button;
        done_res.address = cmd_q.address;
        done_res.full    = 1'b0;
      end
      default: begin
      end
    endcase
  end

  assign res_o      = (state_q == ST_DONE) ? done_res : pend_q;
  assign res_push_o = (state_q == ST_DONE) ? (done_go && done_need)
                                           : (scan_adv && hit && pend_v_q);
  assign cmd_pop_o  = (state_q == ST_IDLE) && !cmd_empty_i;

  // one read per cycle; hold the address while stalled
  always_comb begin
    case (state_q)
      ST_SCAN: raddr = (scan_adv && !last_entry) ? idx_q + 1'b1 : idx_q;
      ST_DONE: raddr = idx_q;
      default: raddr = '0;
    endcase
  end

  assign ram_we             = done_go && (cmd_q.op == OP_PUSH) && !tbl_full;
  assign wr_entry.address   = cmd_q.address;
  assign wr_entry.button    = cmd_q.button;
  assign wr_entry.push_time = cmd_q.now;

  sprt_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wslot),
    .wdata_i (wr_entry),
    .raddr_i (raddr),
    .rdata_o (rd_vec)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      idx_q    <= '0;
      valid_q  <= '0;
      found_q  <= 1'b0;
      free_v_q <= 1'b0;
      any_q    <= 1'b0;
      pend_v_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (cmd_pop_o) begin
            idx_q    <= '0;
            found_q  <= 1'b0;
            free_v_q <= 1'b0;
            any_q    <= 1'b0;
            pend_v_q <= 1'b0;
            cnt_q    <= '0;
            state_q  <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (scan_adv) begin
            if (match && !found_q) begin
              found_q <= 1'b1;
            end
            if (!entry_v && !free_v_q) begin
              free_v_q <= 1'b1;
            end
            if (entry_v) begin
              any_q <= 1'b1;
            end
            if (hit) begin
              pend_v_q <= 1'b1;
              cnt_q    <= cnt_q + 1'b1;
            end
            if (last_entry) begin
              state_q <= ST_DONE;
            end else begin
              idx_q <= idx_q + 1'b1;
            end
          end
        end
        ST_DONE: begin
          if (done_go) begin
            case (cmd_q.op)
              OP_PUSH: begin
                if (!tbl_full) begin
                  valid_q[wslot] <= 1'b1;
                end
              end
              OP_RELEASE: begin
                if (found_q) begin
                  valid_q[slot_q] <= 1'b0;
                end
              end
              default: begin
                if (any_q && (min_age_q > cancel_ext)) begin
                  valid_q <= '0;
                end
              end
            endcase
            pend_v_q <= 1'b0;
            state_q  <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      cmd_q     <= cmd_i;
      min_age_q <= '1;
    end
    if (scan_adv) begin
      if (match && !found_q) begin
        slot_q <= idx_q;
        long_q <= (age >= wait_ext);
      end
      if (!entry_v && !free_v_q) begin
        free_q <= idx_q;
      end
      if (entry_v && (age < min_age_q)) begin
        min_age_q <= age;
      end
      if (hit) begin
        pend_q.kind    <= EV_REPEAT;
        pend_q.button  <= rd_entry.button;
        pend_q.address <= rd_entry.address;
        pend_q.full    <= 1'b0;
        pend_q.last    <= 1'b0;
      end
    end
  end

endmodule

>>> tb/switch_press_repeat_tracker_tb.sv
`timescale 1ns / 1ps
module switch_press_repeat_tracker_tb;
  import sprt_pkg::*;

  localparam int SLOTS      = 8;
  localparam int MAX_EVENTS = 8;
  localparam int POOL_SIZE  = 10;

  localparam logic CMD_REPORT = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  typedef struct packed {
    logic              cmd;
    logic [ADDR_W-1:0] addr;
    logic [STAT_W-1:0] status;
    logic [TIME_W-1:0] now_ms;
  } switch_item_t;

  logic clk_i;
  logic rst_ni = 1'b0;

  logic              push = 1'b0;
  logic              full;
  logic              command_i = CMD_REPORT;
  logic [ADDR_W-1:0] device_address_i = '0;
  logic [STAT_W-1:0] switch_status_i = '0;
  logic [TIME_W-1:0] now_ms_i = '0;

  logic              empty;
  logic              pop = 1'b0;
  logic [1:0]        event_kind_o;
  logic [BTN_W-1:0]  button_id_o;
  logic [ADDR_W-1:0] event_address_o;
  logic              table_full_o;
  logic              last_of_run_o;

  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  switch_press_repeat_tracker #(
    .TABLE_ENTRIES(SLOTS)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .command_i       (command_i),
    .device_address_i(device_address_i),
    .switch_status_i (switch_status_i),
    .now_ms_i        (now_ms_i),
    .empty           (empty),
    .pop             (pop),
    .event_kind_o    (event_kind_o),
    .button_id_o     (button_id_o),
    .event_address_o (event_address_o),
    .table_full_o    (table_full_o),
    .last_of_run_o   (last_of_run_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // press table and registers as the block should hold them
  logic              press_valid [SLOTS];
  logic [ADDR_W-1:0] press_addr  [SLOTS];
  button_e           press_button[SLOTS];
  logic [TIME_W-1:0] press_time  [SLOTS];
  logic [CFG_W-1:0]  repeat_wait  = REPEAT_WAIT_RST;
  logic [CFG_W-1:0]  cancel_limit = CANCEL_AFTER_RST;

  switch_item_t switch_queue[$];
  res_t         expected_events[$];

  int  items_issued   = 0;
  int  items_accepted = 0;
  int  events_checked = 0;
  int  settings_run   = 1;
  int  mismatches     = 0;
  int  send_idle_pct  = 0;
  int  recv_stall_pct = 0;
  bit  item_taken     = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5000000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic void predict_events(input switch_item_t it);
    button_e           btn;
    kind_e             kind;
    logic              no_room;
    logic              any_valid;
    logic [TIME_W-1:0] age;
    logic [TIME_W-1:0] min_age;
    res_t              batch[MAX_EVENTS];
    int                slot;
    int                n;
    int                i;
    n = 0;
    slot = -1;
    if (it.cmd == CMD_REPORT) begin
      if (it.status[BIT_B1]) btn = BTN_B1;
      else if (it.status[BIT_B0]) btn = BTN_B0;
      else if (it.status[BIT_A1]) btn = BTN_A1;
      else btn = BTN_A0;
      for (i = SLOTS - 1; i >= 0; i--) begin
        if (press_valid[i] && press_addr[i] == it.addr) slot = i;
      end
      if (it.status[BIT_PRESSED]) begin
        if (slot < 0) begin
          for (i = SLOTS - 1; i >= 0; i--) begin
            if (!press_valid[i]) slot = i;
          end
        end
        no_room = (slot < 0);
        if (!no_room) begin
          press_valid[slot]  = 1'b1;
          press_addr[slot]   = it.addr;
          press_button[slot] = btn;
          press_time[slot]   = it.now_ms;
        end
        batch[n++] = '{EV_PUSHED, btn, it.addr, no_room, 1'b0};
      end else begin
        kind = EV_SHORT;
        if (slot >= 0) begin
          age = it.now_ms - press_time[slot];
          if (age >= TIME_W'(repeat_wait)) kind = EV_LONG;
          press_valid[slot] = 1'b0;
        end
        batch[n++] = '{kind, btn, it.addr, 1'b0, 1'b0};
      end
    end else begin
      any_valid = 1'b0;
      min_age = '1;
      for (i = 0; i < SLOTS; i++) begin
        if (press_valid[i]) begin
          age = it.now_ms - press_time[i];
          any_valid = 1'b1;
          if (age < min_age) min_age = age;
          if (age > TIME_W'(repeat_wait) && n < MAX_EVENTS)
            batch[n++] = '{EV_REPEAT, press_button[i], press_addr[i], 1'b0, 1'b0};
        end
      end
      // cancel happens after the repeats of this tick went out
      if (any_valid && min_age > TIME_W'(cancel_limit)) begin
        for (i = 0; i < SLOTS; i++) press_valid[i] = 1'b0;
      end
    end
    if (n > 0) batch[n-1].last = 1'b1;
    for (i = 0; i < n; i++) expected_events = {expected_events, batch[i]};
  endfunction

  function automatic void check_field(input string name, input logic [ADDR_W-1:0] want,
                                      input logic [ADDR_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  // input side: hold each item until it is taken
  always @(negedge clk_i) begin
    switch_item_t it;
    if (!rst_ni) begin
      push <= 1'b0;
    end else if (!push || item_taken) begin
      if (switch_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        it = switch_queue.pop_front();
        push             <= 1'b1;
        command_i        <= it.cmd;
        device_address_i <= it.addr;
        switch_status_i  <= it.status;
        now_ms_i         <= it.now_ms;
      end else begin
        push <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    pop <= rst_ni && ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    res_t want;
    if (!rst_ni) begin
      item_taken = 1'b0;
    end else begin
      item_taken = push && !full;
      if (item_taken) begin
        items_accepted++;
        predict_events('{command_i, device_address_i, switch_status_i, now_ms_i});
      end
      if (pop && !empty) begin
        if (expected_events.size() == 0) begin
          $error("event beat with nothing expected: kind %0d addr %0h",
                 event_kind_o, event_address_o);
          mismatches++;
        end else begin
          want = expected_events.pop_front();
          events_checked++;
          check_field("event_kind", ADDR_W'(want.kind), ADDR_W'(event_kind_o));
          check_field("button_id", ADDR_W'(want.button), ADDR_W'(button_id_o));
          check_field("event_address", want.address, event_address_o);
          check_field("table_full", ADDR_W'(want.full), ADDR_W'(table_full_o));
          check_field("last_of_run", ADDR_W'(want.last), ADDR_W'(last_of_run_o));
        end
      end
    end
  end

  task automatic queue_item(input logic cmd, input logic [ADDR_W-1:0] addr,
                            input logic [STAT_W-1:0] status, input logic [TIME_W-1:0] now_ms);
    switch_item_t it;
    it = '{cmd, addr, status, now_ms};
    switch_queue = {switch_queue, it};
    items_issued++;
  endtask

  task automatic write_register(input logic reg_sel, input logic [CFG_W-1:0] value);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {reg_sel, 2'b00};
    pwdata  = APB_DW'(value);
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    if (reg_sel == REG_REPEAT_WAIT) repeat_wait = value;
    else cancel_limit = value;
  endtask

  // a tick may give no event while the back end is still busy, so pad the drain
  task automatic drain_events();
    while (items_accepted != items_issued || expected_events.size() != 0)
      @(negedge clk_i);
    repeat (4 * (SLOTS + 2)) @(negedge clk_i);
  endtask

  task automatic queue_directed_items();
    logic [ADDR_W-1:0] addr[SLOTS];
    logic [STAT_W-1:0] status[SLOTS];
    logic [TIME_W-1:0] t0;
    logic [ADDR_W-1:0] stranger;
    int                k;
    addr   = '{48'h0, 48'hFFFF_FFFF_FFFF, 48'h0000_0000_0001, 48'h8000_0000_0000,
               48'hA5A5_5A5A_C3C3, 48'h1234_5678_9ABC, 48'hFEDC_BA98_7654,
               48'h0F0F_F0F0_3C3C};
    status = '{8'h01, 8'h05, 8'h09, 8'h11, 8'hFF, 8'h03, 8'h0D, 8'h15};
    t0 = 32'hFFFF_FE00;  // later times below cross the 32-bit wrap
    stranger = 48'h5555_5555_5555;
    for (k = 0; k < SLOTS; k++) queue_item(CMD_REPORT, addr[k], status[k], t0);
    queue_item(CMD_REPORT, stranger, 8'h11, t0);            // table full
    queue_item(CMD_TICK, '0, '0, t0 + 500);                 // age equal to wait: quiet
    queue_item(CMD_TICK, '0, '0, t0 + 501);                 // eight repeats
    queue_item(CMD_REPORT, addr[2], 8'h09, t0 + 520);       // push over stored address
    queue_item(CMD_REPORT, addr[3], 8'hFE, t0 + 500);       // long at exactly wait
    queue_item(CMD_REPORT, addr[2], 8'h08, t0 + 1019);      // short, one below wait
    queue_item(CMD_REPORT, stranger, 8'h00, t0 + 1019);     // release of unknown switch
    queue_item(CMD_TICK, '0, '0, t0 + 3000);                // newest at cancel limit
    queue_item(CMD_TICK, '0, '0, t0 + 3001);                // repeats, then cancel
    queue_item(CMD_TICK, '0, '0, t0 + 3002);                // empty table
  endtask

  task automatic queue_random_items(input int count);
    logic [ADDR_W-1:0] pool[POOL_SIZE];
    logic [TIME_W-1:0] clock_ms;
    logic [STAT_W-1:0] status;
    int unsigned       wait_val;
    int unsigned       step;
    int                sel;
    int                k;
    wait_val = 32'(repeat_wait);
    clock_ms = $urandom;
    for (k = 0; k < POOL_SIZE; k++) pool[k] = ADDR_W'({$urandom, $urandom});
    for (k = 0; k < count; k++) begin
      sel = $urandom_range(99);
      if (sel < 60) step = $urandom_range(wait_val + wait_val / 2 + 2, 0);
      else if (sel < 85) step = $urandom_range(2 * wait_val + 2, wait_val);
      else if (sel < 95) step = cancel_limit + $urandom_range(1000, 1);
      else step = $urandom;
      clock_ms += step;
      status = STAT_W'($urandom);
      sel = $urandom_range(99);
      if (sel < 45) begin
        status[BIT_PRESSED] = 1'b1;
        queue_item(CMD_REPORT, pool[$urandom_range(POOL_SIZE - 1)], status, clock_ms);
      end else if (sel < 75) begin
        status[BIT_PRESSED] = 1'b0;
        queue_item(CMD_REPORT, pool[$urandom_range(POOL_SIZE - 1)], status, clock_ms);
      end else if (sel < 95) begin
        queue_item(CMD_TICK, ADDR_W'({$urandom, $urandom}), status, clock_ms);
      end else begin
        queue_item(CMD_REPORT, ADDR_W'({$urandom, $urandom}), status, clock_ms);
      end
    end
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] wait_val, input logic [CFG_W-1:0] cancel_val,
                           input int send_pct, input int recv_pct, input int count);
    write_register(REG_REPEAT_WAIT, wait_val);
    write_register(REG_CANCEL_AFTER, cancel_val);
    settings_run++;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    queue_random_items(count);
    drain_events();
  endtask

  initial begin
    for (int i = 0; i < SLOTS; i++) press_valid[i] = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    queue_directed_items();
    drain_events();

    run_phase(CFG_W'(0), CFG_W'(0), 0, 0, 22);
    run_phase(CFG_W'(1048575), CFG_W'(1048575), 87, 0, 22);
    run_phase(CFG_W'($urandom_range(800, 200)), CFG_W'($urandom_range(4000, 1000)), 0, 87, 22);
    run_phase(CFG_W'($urandom_range(1048575)), CFG_W'($urandom_range(1048575)), 6, 6, 22);
    run_phase(CFG_W'(0), CFG_W'(1048575), 0, 0, 22);

    $display("switch tracker: %0d reports and ticks under %0d register settings",
             items_accepted, settings_run);
    $display("switch tracker: %0d events compared, %0d mismatches",
             events_checked, mismatches);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/sprt_pkg.sv
hdl/sprt_ram.sv
hdl/sprt_fifo.sv
hdl/sprt_front.sv
hdl/sprt_back.sv
hdl/switch_press_repeat_tracker.sv
tb/switch_press_repeat_tracker_tb.sv
